>>> design/tcce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// short queue between front and back, power of two
	localparam int QUEUE_DEPTH = 2;

	localparam int TAB_STOP = 8;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 2'd1;

	typedef logic [2:0] kind_t;

	localparam kind_t K_NOP   = 3'd0;
	localparam kind_t K_PRINT = 3'd1;
	localparam kind_t K_BS    = 3'd2;
	localparam kind_t K_TAB   = 3'd3;
	localparam kind_t K_CR    = 3'd4;
	localparam kind_t K_LF    = 3'd5;
	localparam kind_t K_CLEAR = 3'd6;
	localparam kind_t K_READ  = 3'd7;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} entry_t;

endpackage
`default_nettype wire

>>> design/tcce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcce_ram
	import tcce_pkg::*;
#(
	parameter int WIDTH = CELL_W,
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire  [$clog2(DEPTH)-1:0] wr_addr,
	input  wire  [WIDTH-1:0]         wr_data,
	input  wire                      rd_en,
	input  wire  [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/tcce_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module tcce_queue
	import tcce_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  wire    wr_valid,
	output logic   wr_ready,
	input  entry_t wr_entry,
	output logic   rd_valid,
	input  wire    rd_ready,
	output entry_t rd_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/tcce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_front
// Input side: takes words from the stream and classifies them for the back.
// ----------------------------------------------------------------------------
module tcce_front
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire  [S_TDATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8]
	input  wire  [OP_W-1:0]      s_axis_tuser,   // op[1:0]
	input  wire                  init_busy,
	output logic                 q_valid,
	input  wire                  q_ready,
	output entry_t               q_entry
);

	localparam int CELL_COUNT = COLUMNS * ROWS;

	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;
	logic              in_range;
	kind_t             kind;

	assign char_code  = s_axis_tdata[CHAR_W-1:0];
	assign cell_index = s_axis_tdata[CHAR_W +: IDX_W];
	assign in_range   = (32'(cell_index) < 32'(CELL_COUNT));

	always_comb begin
		kind = K_NOP;
		unique case (s_axis_tuser)
			OP_PUT: begin
				unique case (char_code)
					CHAR_BS:  kind = K_BS;
					CHAR_TAB: kind = K_TAB;
					CHAR_CR:  kind = K_CR;
					CHAR_LF:  kind = K_LF;
					default:  kind = (char_code >= CHAR_SPACE) ? K_PRINT : K_NOP;
				endcase
			end
			OP_CLEAR: kind = K_CLEAR;
			// reads past the screen return zero, same as a no-op
			OP_READ:  kind = in_range ? K_READ : K_NOP;
			default:  kind = K_NOP;
		endcase
	end

	assign q_entry.kind       = kind;
	assign q_entry.char_code  = char_code;
	assign q_entry.cell_index = cell_index;

	// nothing taken while the screen is being cleared after reset
	assign q_valid       = s_axis_tvalid && !init_busy;
	assign s_axis_tready = q_ready && !init_busy;

endmodule
`default_nettype wire

>>> design/tcce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_back
// Execution side: cursor, screen memory sequencer (print, read, clear,
// scroll, reset clearing pass) and the output register.
// ----------------------------------------------------------------------------
module tcce_back
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_ready,
	input  entry_t               q_entry,
	input  wire  [ATTR_W-1:0]    text_attr,
	input  wire  [ATTR_W-1:0]    blank_attr,
	output logic                 init_busy,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata    // cell_data[15:0], cursor_index[26:16]
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W      = $clog2(ROWS + 1);

	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0]  TAB_C     = COL_W'(TAB_STOP);
	localparam logic [COL_W-1:0]  TAB_MASK  = ~COL_W'(TAB_STOP - 1);
	localparam logic [ROW_W-1:0]  ROWS_R    = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_FILL  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              mv_v_s1;
	logic [ADDR_W-1:0] mv_addr_s1;
	logic [CELL_W-1:0] res_data_q;
	logic              out_valid_q;
	logic [CELL_W-1:0] out_data_q;
	logic [IDX_W-1:0]  out_cur_q;

	logic [COL_W-1:0]  col_a;
	logic [ROW_W-1:0]  row_a;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_w;
	logic [ROW_W-1:0]  row_n;
	logic              scroll;
	logic [ADDR_W-1:0] cur_lin;
	logic              out_free;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [CELL_W-1:0] rd_data;

	assign cur_lin  = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
	assign out_free = !out_valid_q || m_axis_tready;

	// teletype cursor motion
	always_comb begin
		col_a = col_q;
		row_a = row_q;
		case (q_entry.kind)
			K_BS: begin
				if (col_q != '0) begin
					col_a = col_q - COL_W'(1);
				end
			end
			K_TAB:   col_a = (col_q + TAB_C) & TAB_MASK;
			K_CR:    col_a = '0;
			K_LF: begin
				col_a = '0;
				row_a = row_q + ROW_W'(1);
			end
			K_PRINT: col_a = col_q + COL_W'(1);
			default: ;
		endcase
		if (col_a >= COLS_C) begin
			col_n = '0;
			row_w = row_a + ROW_W'(1);
		end else begin
			col_n = col_a;
			row_w = row_a;
		end
		scroll = (row_w >= ROWS_R);
		row_n  = scroll ? LAST_ROW : row_w;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = {blank_attr, CHAR_SPACE};
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		unique case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_data = RESET_CELL;
			end
			S_IDLE: begin
				if (q_valid && q_entry.kind == K_PRINT) begin
					wr_en   = 1'b1;
					wr_addr = cur_lin;
					wr_data = {text_attr, q_entry.char_code};
				end
				if (q_valid && q_entry.kind == K_READ) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(q_entry.cell_index);
				end
			end
			S_MOVE, S_DRAIN: begin
				// read one row ahead, write the previous read one row up
				rd_en   = (state_q == S_MOVE);
				wr_en   = mv_v_s1;
				wr_addr = mv_addr_s1;
				wr_data = rd_data;
			end
			S_FILL: begin
				wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_MOVE) begin
			mv_addr_s1 <= ptr_q - COLS_A;
		end
		if (state_q == S_IDLE && q_valid) begin
			res_data_q <= '0;
		end else if (state_q == S_RD) begin
			res_data_q <= rd_data;
		end
		if (state_q == S_DONE && out_free) begin
			out_data_q <= res_data_q;
			out_cur_q  <= IDX_W'(cur_lin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			mv_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_entry.kind)
							K_READ:  state_q <= S_RD;
							K_CLEAR: begin
								ptr_q   <= '0;
								state_q <= S_FILL;
							end
							default: begin
								col_q <= col_n;
								row_q <= row_n;
								if (scroll) begin
									ptr_q   <= COLS_A;
									state_q <= S_MOVE;
								end else begin
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_RD: state_q <= S_DONE;
				S_MOVE: begin
					mv_v_s1 <= 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				S_DRAIN: begin
					mv_v_s1 <= 1'b0;
					ptr_q   <= LAST_BASE;
					state_q <= S_FILL;
				end
				S_FILL: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_q == LAST_ADDR) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_ready       = (state_q == S_IDLE);
	assign init_busy     = (state_q == S_INIT);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W - CELL_W - IDX_W)'(0), out_cur_q, out_data_q};

endmodule
`default_nettype wire

>>> design/text_console_character_engine.sv
`default_nettype none
// Path: put and control codes go from the queue to the output register, a read
//   through the RAM read first, a clear and a scrolling put through their cell passes.
// Throughput: one word at a time; the single-port-pair screen RAM sets the
//   clear and scroll cost at one cell per cycle. The queue takes words meanwhile.
// Reset: async, active low. A clearing pass over all ROWS*COLUMNS cells (2000 by
//   default) fills the screen with 0x0720; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// text_console_character_engine
// Teletype console engine: screen memory, cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
module text_console_character_engine
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire  [S_TDATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8]
	input  wire  [OP_W-1:0]      s_axis_tuser,   // op[1:0]
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // cell_data[15:0], cursor_index[26:16]
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [ATTR_W-1:0]    cfg_data
);

	logic [ATTR_W-1:0] text_attr_q;
	logic [ATTR_W-1:0] blank_attr_q;
	logic              init_busy;
	logic              fq_valid;
	logic              fq_ready;
	entry_t            fq_entry;
	logic              bq_valid;
	logic              bq_ready;
	entry_t            bq_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q  <= RESET_ATTR;
			blank_attr_q <= RESET_ATTR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TEXT_ATTR:  text_attr_q  <= cfg_data;
				CFG_BLANK_ATTR: blank_attr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcce_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.init_busy     (init_busy),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_entry       (fq_entry)
	);

	tcce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_entry (fq_entry),
		.rd_valid (bq_valid),
		.rd_ready (bq_ready),
		.rd_entry (bq_entry)
	);

	tcce_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (bq_valid),
		.q_ready       (bq_ready),
		.q_entry       (bq_entry),
		.text_attr     (text_attr_q),
		.blank_attr    (blank_attr_q),
		.init_busy     (init_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_no_input_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !s_axis_tready)
		else $error("word accepted during clearing pass");

	a_no_output_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !m_axis_tvalid)
		else $error("result shown during clearing pass");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((COLUMNS * ROWS > 2047) ||
			(m_axis_tdata[26:16] < 11'(COLUMNS * ROWS))))
		else $error("cursor index off screen");
`endif

endmodule
`default_nettype wire

>>> dv/text_console_character_engine_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the word, result and register channels of the console engine, keeps
// its own screen, cursor and attribute state, and compares every result word
// with the predicted one in arrival order.
// ----------------------------------------------------------------------------
module text_console_checker
	import tcce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	input  wire                  s_axis_tready,
	input  wire  [S_TDATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8]
	input  wire  [OP_W-1:0]      s_axis_tuser,   // op[1:0]
	input  wire                  m_axis_tvalid,
	input  wire                  m_axis_tready,
	input  wire  [M_TDATA_W-1:0] m_axis_tdata,   // cell_data[15:0], cursor_index[26:16]
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [ATTR_W-1:0]    cfg_data,
	input  wire                  end_of_test,
	output int                   errors,
	output int                   outstanding,
	output int                   checked
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [CELL_W-1:0] data;
		logic [IDX_W-1:0]  cursor;
	} console_result_t;

	logic [CELL_W-1:0] screen [CELLS];
	int                cur_col;
	int                cur_row;
	logic [ATTR_W-1:0] text_attr;
	logic [ATTR_W-1:0] blank_attr;
	console_result_t   pending_results [$];
	int                err_n = 0;
	int                checked_n = 0;
	bit                closed;

	function automatic void blank_cells(input int first, input int count);
		for (int i = first; i < first + count; i++)
			screen[i] = {blank_attr, CHAR_SPACE};
	endfunction

	function automatic void put_char(input logic [CHAR_W-1:0] c);
		if (c == CHAR_BS) begin
			if (cur_col != 0)
				cur_col--;
		end else if (c == CHAR_TAB) begin
			cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
		end else if (c == CHAR_CR) begin
			cur_col = 0;
		end else if (c == CHAR_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (c >= CHAR_SPACE) begin
			screen[cur_row * COLUMNS + cur_col] = {text_attr, c};
			cur_col++;
		end
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		// scroll up one line, bottom line gets blanks
		if (cur_row >= ROWS) begin
			for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			blank_cells((ROWS - 1) * COLUMNS, COLUMNS);
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic console_result_t console_step(input logic [OP_W-1:0] op,
		input logic [CHAR_W-1:0] c, input logic [IDX_W-1:0] idx);
		console_result_t r;
		r.data = '0;
		case (op)
			OP_PUT:   put_char(c);
			OP_CLEAR: blank_cells(0, CELLS);
			OP_READ: begin
				if (idx < CELLS)
					r.data = screen[idx];
			end
			default: ;
		endcase
		r.cursor = IDX_W'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_result_t got;
		console_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = RESET_CELL;
			cur_col = 0;
			cur_row = 0;
			text_attr = RESET_ATTR;
			blank_attr = RESET_ATTR;
			pending_results.delete();
			closed = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TEXT_ATTR)
					text_attr = cfg_data;
				else if (cfg_index == CFG_BLANK_ATTR)
					blank_attr = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(console_step(s_axis_tuser,
					s_axis_tdata[CHAR_W-1:0], s_axis_tdata[CHAR_W +: IDX_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.data = m_axis_tdata[CELL_W-1:0];
				got.cursor = m_axis_tdata[CELL_W +: IDX_W];
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %h", $time,
						m_axis_tdata);
					err_n++;
				end else begin
					want = pending_results.pop_front();
					checked_n++;
					if (got.data !== want.data) begin
						$display("%0t: cell_data expected %h, got %h", $time, want.data,
							got.data);
						err_n++;
					end
					if (got.cursor !== want.cursor) begin
						$display("%0t: cursor_index expected %0d, got %0d", $time,
							want.cursor, got.cursor);
						err_n++;
					end
				end
			end
			if (end_of_test && !closed) begin
				closed = 1'b1;
				if (pending_results.size() != 0) begin
					$display("%0t: %0d results never arrived, expected next %h, got none",
						$time, pending_results.size(), pending_results[0]);
					err_n += pending_results.size();
				end
			end
		end
		errors <= err_n;
		outstanding <= pending_results.size();
		checked <= checked_n;
	end

endmodule
`default_nettype wire

>>> dv/tb_text_console_character_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_text_console_character_engine
// Drives put, clear, read and unused-op words into the console engine under
// three handshake idling patterns and several attribute settings; the checker
// beside the engine predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_text_console_character_engine;
	import tcce_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CELLS         = DEF_COLUMNS * DEF_ROWS;
	localparam int IDX_MAX       = (1 << IDX_W) - 1;
	localparam int CYCLE_LIMIT   = 4_000_000;
	// longer than a clear or a scrolling put
	localparam int SETTLE_CYCLES = CELLS + 2 * DEF_COLUMNS + 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	wire                  s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // char_code[7:0], cell_index[18:8]
	logic [OP_W-1:0]      s_axis_tuser = '0;   // op[1:0]
	wire                  m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	wire  [M_TDATA_W-1:0] m_axis_tdata;        // cell_data[15:0], cursor_index[26:16]
	logic                 cfg_valid = 1'b0;
	wire                  cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ATTR_W-1:0]    cfg_data = '0;
	logic                 end_of_test = 1'b0;

	int errors;
	int outstanding;
	int checked;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_sent = 0;
	int cycles = 0;

	always #10 clk = ~clk;

	text_console_character_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	text_console_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.end_of_test   (end_of_test),
		.errors        (errors),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_text_console_character_engine: errors");
			$finish;
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] c,
		input logic [IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - CHAR_W - IDX_W){1'b0}}, idx, c};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// hold the sender until the last predicted result is out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_attributes(input logic [ATTR_W-1:0] text_attr,
		input logic [ATTR_W-1:0] blank_attr);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TEXT_ATTR;
		cfg_data <= text_attr;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_BLANK_ATTR;
		cfg_data <= blank_attr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_word();
		int pick;
		logic [CHAR_W-1:0] c;
		pick = $urandom_range(0, 99);
		c = CHAR_W'($urandom_range(0, 255));
		if (pick < 3) begin
			send_word(OP_CLEAR, c, IDX_W'($urandom_range(0, IDX_MAX)));
		end else if (pick < 12) begin
			send_word(OP_READ, c, IDX_W'($urandom_range(0, CELLS - 1)));
		end else if (pick < 13) begin
			send_word(OP_READ, c, IDX_W'($urandom_range(CELLS, IDX_MAX)));
		end else if (pick < 15) begin
			send_word(OP_UNUSED, c, IDX_W'($urandom_range(0, IDX_MAX)));
		end else begin
			// line feeds weighted up so the cursor reaches the bottom and scrolls
			pick = $urandom_range(0, 99);
			if (pick < 55)
				c = CHAR_W'($urandom_range(CHAR_SPACE, 255));
			else if (pick < 75)
				c = CHAR_LF;
			else if (pick < 80)
				c = CHAR_CR;
			else if (pick < 87)
				c = CHAR_TAB;
			else if (pick < 93)
				c = CHAR_BS;
			else
				c = CHAR_W'($urandom_range(0, CHAR_SPACE - 1));
			send_word(OP_PUT, c, IDX_W'($urandom_range(0, IDX_MAX)));
		end
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) begin
			send_random_word();
			if (k % 64 == 63)
				wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 37;
		recv_idle_pct = 46;
		// power-up screen contents, out-of-range reads, an unused op and the control codes
		send_word(OP_READ, 8'h00, '0);
		send_word(OP_READ, 8'hFF, IDX_W'(CELLS - 1));
		send_word(OP_READ, 8'h00, IDX_W'(CELLS));
		send_word(OP_READ, 8'h00, IDX_W'(IDX_MAX));
		send_word(OP_UNUSED, 8'hFF, IDX_W'(IDX_MAX));
		send_word(OP_PUT, CHAR_SPACE, '0);
		send_word(OP_PUT, 8'h41, '0);
		send_word(OP_PUT, 8'hFF, '0);
		send_word(OP_PUT, CHAR_BS, '0);
		send_word(OP_PUT, CHAR_CR, '0);
		send_word(OP_PUT, CHAR_BS, '0);
		send_word(OP_PUT, CHAR_TAB, '0);
		send_word(OP_PUT, CHAR_TAB, '0);
		send_word(OP_PUT, CHAR_LF, '0);
		send_word(OP_PUT, 8'h00, '0);
		send_word(OP_PUT, 8'h1F, '0);
		send_word(OP_PUT, 8'h07, '0);
		send_word(OP_READ, 8'h00, IDX_W'(2));
		wait_drained();
		set_attributes(8'h00, 8'hFF);
		send_word(OP_PUT, 8'h7E, '0);
		send_word(OP_CLEAR, 8'h00, '0);
		send_word(OP_READ, 8'h00, '0);
		send_word(OP_READ, 8'h00, IDX_W'(DEF_COLUMNS));
		run_random(130);

		wait_drained();
		send_idle_pct = 46;
		recv_idle_pct = 37;
		set_attributes(8'hFF, 8'h00);
		run_random(135);

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_attributes(ATTR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)));
		run_random(135);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		$display("summary: %0d words sent, %0d result words compared", words_sent, checked);
		$display("summary: all ops, control codes, wrap, scroll, clears, three attribute sets");
		if (errors == 0)
			$display("tb_text_console_character_engine: clean");
		else
			$display("tb_text_console_character_engine: errors");
		$finish;
	end

endmodule
`default_nettype wire
